@@ src/ufpc_pkg.sv @@
// Shared types and constants for the union-find path compression unit.
package ufpc_pkg;

    localparam int ElemW  = 10;
    localparam int TdataW = 24;

    typedef logic [ElemW-1:0] t_elem;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_START,
        S_WALK,
        S_COMP_START,
        S_COMP,
        S_PHASE_END,
        S_LINK,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_COMP_START,
        OP_COMP_STEP,
        OP_LINK,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_b;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_start_end;
        logic walk_end;
        logic comp_start_end;
        logic comp_end;
        logic req_join;
        logic out_busy;
    } t_status;

endpackage

@@ src/ufpc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ufpc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ufpc_ctrl.sv @@
// Controller state machine: sequences clear, walk, compress and link steps.
module ufpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  ufpc_pkg::t_status i_status,
    output ufpc_pkg::t_cmd    o_cmd
);

    ufpc_pkg::t_state r_state, n_state;
    logic             r_sel_b, n_sel_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufpc_pkg::S_CLEAR;
            r_sel_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel_b <= n_sel_b;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_sel_b = r_sel_b;
        unique case (r_state)
            ufpc_pkg::S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ufpc_pkg::S_IDLE;
                end
            end
            ufpc_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_sel_b = 1'b0;
                    n_state = ufpc_pkg::S_WALK_START;
                end
            end
            ufpc_pkg::S_WALK_START: begin
                n_state = i_status.walk_start_end ? ufpc_pkg::S_COMP_START
                                                  : ufpc_pkg::S_WALK;
            end
            ufpc_pkg::S_WALK: begin
                if (i_status.walk_end) begin
                    n_state = ufpc_pkg::S_COMP_START;
                end
            end
            ufpc_pkg::S_COMP_START: begin
                n_state = i_status.comp_start_end ? ufpc_pkg::S_PHASE_END
                                                  : ufpc_pkg::S_COMP;
            end
            ufpc_pkg::S_COMP: begin
                if (i_status.comp_end) begin
                    n_state = ufpc_pkg::S_PHASE_END;
                end
            end
            ufpc_pkg::S_PHASE_END: begin
                if (r_sel_b) begin
                    n_state = ufpc_pkg::S_LINK;
                end else if (i_status.req_join) begin
                    n_sel_b = 1'b1;
                    n_state = ufpc_pkg::S_WALK_START;
                end else begin
                    n_state = ufpc_pkg::S_DONE;
                end
            end
            ufpc_pkg::S_LINK: begin
                n_state = ufpc_pkg::S_DONE;
            end
            ufpc_pkg::S_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ufpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ufpc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op    = ufpc_pkg::OP_NONE;
        o_cmd.sel_b = r_sel_b;
        o_s_tready  = 1'b0;
        unique case (r_state)
            ufpc_pkg::S_CLEAR:      o_cmd.op = ufpc_pkg::OP_CLEAR;
            ufpc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = ufpc_pkg::OP_LOAD;
                end
            end
            ufpc_pkg::S_WALK_START: o_cmd.op = ufpc_pkg::OP_WALK_START;
            ufpc_pkg::S_WALK:       o_cmd.op = ufpc_pkg::OP_WALK_STEP;
            ufpc_pkg::S_COMP_START: o_cmd.op = ufpc_pkg::OP_COMP_START;
            ufpc_pkg::S_COMP:       o_cmd.op = ufpc_pkg::OP_COMP_STEP;
            ufpc_pkg::S_PHASE_END:  o_cmd.op = ufpc_pkg::OP_NONE;
            ufpc_pkg::S_LINK:       o_cmd.op = ufpc_pkg::OP_LINK;
            ufpc_pkg::S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = ufpc_pkg::OP_OUT;
                end
            end
            default:                o_cmd.op = ufpc_pkg::OP_NONE;
        endcase
    end

endmodule

@@ src/ufpc_dpath.sv @@
// Datapath: request registers, parent table, walk pointer and result register.
module ufpc_dpath #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ufpc_pkg::t_cmd                i_cmd,
    output ufpc_pkg::t_status             o_status,
    input  logic                          i_req_type,
    input  logic [ufpc_pkg::ElemW-1:0]    i_elem_a,
    input  logic [ufpc_pkg::ElemW-1:0]    i_elem_b,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ufpc_pkg::ElemW-1:0]    o_root_a,
    output logic [ufpc_pkg::ElemW-1:0]    o_root_b
);

    localparam int AW = $clog2(NUM_ELEMENTS);
    localparam logic [16:0] NumElem = 17'(NUM_ELEMENTS);
    localparam logic [AW-1:0] LastAddr = AW'(NUM_ELEMENTS - 1);

    function automatic logic has_entry(input ufpc_pkg::t_elem e);
        return {7'b0, e} < NumElem;
    endfunction

    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            r_req, n_req;
    ufpc_pkg::t_elem r_a, n_a, r_b, n_b;
    ufpc_pkg::t_elem r_node, n_node, r_root, n_root;
    ufpc_pkg::t_elem r_ra, n_ra, r_rb, n_rb;
    ufpc_pkg::t_elem r_oa, n_oa, r_ob, n_ob;

    logic            we, re;
    logic [AW-1:0]   waddr, raddr;
    ufpc_pkg::t_elem wdata, rdata, elem_sel;

    ufpc_ram #(
        .WIDTH (ufpc_pkg::ElemW),
        .DEPTH (NUM_ELEMENTS)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign elem_sel = i_cmd.sel_b ? r_b : r_a;

    always_comb begin
        o_status.clr_last       = (r_cnt == LastAddr);
        o_status.walk_start_end = !has_entry(elem_sel);
        o_status.walk_end       = (rdata == r_node) || !has_entry(rdata);
        o_status.comp_start_end = (elem_sel == r_root) || !has_entry(elem_sel);
        o_status.comp_end       = (rdata == r_root) || !has_entry(rdata);
        o_status.req_join       = r_req;
        o_status.out_busy       = r_out_valid && !i_m_tready;
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_a         = r_a;
        n_b         = r_b;
        n_node      = r_node;
        n_root      = r_root;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_oa        = r_oa;
        n_ob        = r_ob;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (i_cmd.op)
            ufpc_pkg::OP_NONE: begin
            end
            ufpc_pkg::OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = ufpc_pkg::ElemW'(r_cnt);
                n_cnt = r_cnt + 1'b1;
            end
            ufpc_pkg::OP_LOAD: begin
                n_req = i_req_type;
                n_a   = i_elem_a;
                n_b   = i_elem_b;
            end
            ufpc_pkg::OP_WALK_START: begin
                n_node = elem_sel;
                n_root = elem_sel;
                if (has_entry(elem_sel)) begin
                    re    = 1'b1;
                    raddr = AW'(elem_sel);
                end
            end
            ufpc_pkg::OP_WALK_STEP: begin
                // a self link or an element without entry both end at rdata
                n_node = rdata;
                n_root = rdata;
                if (!o_status.walk_end) begin
                    re    = 1'b1;
                    raddr = AW'(rdata);
                end
            end
            ufpc_pkg::OP_COMP_START: begin
                n_node = elem_sel;
                if (i_cmd.sel_b) begin
                    n_rb = r_root;
                end else begin
                    n_ra = r_root;
                end
                if (!o_status.comp_start_end) begin
                    re    = 1'b1;
                    raddr = AW'(elem_sel);
                end
            end
            ufpc_pkg::OP_COMP_STEP: begin
                // point the current node at the root while fetching the next one
                we     = 1'b1;
                waddr  = AW'(r_node);
                wdata  = r_root;
                n_node = rdata;
                if (!o_status.comp_end) begin
                    re    = 1'b1;
                    raddr = AW'(rdata);
                end
            end
            ufpc_pkg::OP_LINK: begin
                if (has_entry(r_ra)) begin
                    we    = 1'b1;
                    waddr = AW'(r_ra);
                    wdata = r_rb;
                end
            end
            ufpc_pkg::OP_OUT: begin
                n_out_valid = 1'b1;
                n_oa        = r_ra;
                n_ob        = r_req ? r_rb : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_a    <= n_a;
        r_b    <= n_b;
        r_node <= n_node;
        r_root <= n_root;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_oa   <= n_oa;
        r_ob   <= n_ob;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_root_a   = r_oa;
    assign o_root_b   = r_ob;

endmodule

@@ src/union_find_path_compression_unit.sv @@
// Top level of the union-find path compression unit.
// After reset a clearing pass writes entry i = i for every entry; no transfer is taken.
// One item is in work at a time.
// Parent steps go one at a time through the single read port of the parent RAM.
// The result register holds a finished result while the next request is accepted.
module union_find_path_compression_unit #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [9:0] elem_a, [19:10] elem_b, [23:20] zero
    input  logic [ufpc_pkg::TdataW-1:0]   i_s_tdata,
    // [0] req_type
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [9:0] root_a, [19:10] root_b, [23:20] zero
    output logic [ufpc_pkg::TdataW-1:0]   o_m_tdata
);

    ufpc_pkg::t_cmd    cmd;
    ufpc_pkg::t_status status;
    ufpc_pkg::t_elem   root_a, root_b;

    ufpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ufpc_dpath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_req_type (i_s_tuser),
        .i_elem_a   (i_s_tdata[9:0]),
        .i_elem_b   (i_s_tdata[19:10]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_root_a   (root_a),
        .o_root_b   (root_b)
    );

    assign o_m_tdata = {4'b0, root_b, root_a};

endmodule
